// File: rtl/core/lli_pkg.sv
// Shared widths, types and helper functions for the line intersection unit.
`default_nettype none
package lli_pkg;

    localparam int COORD_BITS = 25;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 25;
    localparam int OUT_W      = 48;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int DET1_W  = 2 * COORD_BITS;
    localparam int PP_W    = 2 * COORD_BITS + 2;
    localparam int DET_W   = 2 * COORD_BITS + 3;
    localparam int NUM_W   = 3 * COORD_BITS + 2;
    localparam int NUMA_W  = NUM_W + 1;
    localparam int N_W     = NUMA_W + FRAC_BITS + 2;
    localparam int M_W     = (N_W > OUT_W) ? N_W : OUT_W + 1;
    localparam int R0_W    = M_W - OUT_W;
    localparam int DEN_W   = DET_W + 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int CMP_W   = (R0_W > DEN_W) ? R0_W : DEN_W;

    localparam int FRONT_STAGES = 8;

    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [OUT_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic             found;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [DEN_W-1:0] den;
        lane_t            x;
        lane_t            y;
    } div_item_t;

    typedef struct packed {
        logic             clip;
        logic [OUT_W-1:0] val;
    } sat_t;

    // One restoring division step: the next dividend bit shifts out of the top of quo
    // while the new quotient bit shifts in at the bottom.
    function automatic lane_t div_step(lane_t a, logic [DEN_W-1:0] den);
        logic [REM_W-1:0] sh;
        logic             ge;
        lane_t            r;
        sh = {a.rem[REM_W-2:0], a.quo[OUT_W-1]};
        ge = (sh >= {1'b0, den});
        r.rem = ge ? (sh - {1'b0, den}) : sh;
        r.quo = {a.quo[OUT_W-2:0], ge};
        return r;
    endfunction

    // Applies the sign to the quotient magnitude and saturates to the output range.
    function automatic sat_t saturate(logic [OUT_W-1:0] quo, logic neg, logic ovf);
        sat_t r;
        if (neg) begin
            r.clip = ovf || (quo > SAT_NEG);
            r.val  = r.clip ? SAT_NEG : (~quo + {{(OUT_W-1){1'b0}}, 1'b1});
        end else begin
            r.clip = ovf || quo[OUT_W-1];
            r.val  = r.clip ? SAT_POS : quo;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/lli_front.sv
// Determinant and numerator pipeline that prepares the operands of the divider chain.
`default_nettype none
module lli_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_start_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_start_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_end_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_end_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_start_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_start_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_end_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_end_y,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lli_pkg::div_item_t              out_item
);

    localparam int C  = lli_pkg::COORD_BITS;
    localparam int NS = lli_pkg::FRONT_STAGES;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_in;
    logic [NS:0]   rdy;

    logic signed [C-1:0] ax, ay, bx, by, cx, cy, ex, ey;

    // Stage A
    logic signed [lli_pkg::DIFF_W-1:0] a_dx1_reg, a_dy1_reg, a_dx2_reg, a_dy2_reg;
    logic signed [lli_pkg::DET1_W-1:0] a_p1_reg, a_p2_reg, a_p3_reg, a_p4_reg;
    // Stage B
    logic signed [lli_pkg::DIFF_W-1:0] b_dx1_reg, b_dy1_reg, b_dx2_reg, b_dy2_reg;
    logic signed [lli_pkg::DET1_W-1:0] b_det1_reg, b_det2_reg;
    logic signed [lli_pkg::PP_W-1:0]   b_pd1_reg, b_pd2_reg;
    // Stage C
    logic signed [lli_pkg::DET_W-1:0]  c_det_reg;
    logic signed [lli_pkg::PP_W-1:0]   c_x1h_reg, c_x1l_reg, c_x2h_reg, c_x2l_reg;
    logic signed [lli_pkg::PP_W-1:0]   c_y1h_reg, c_y1l_reg, c_y2h_reg, c_y2l_reg;
    logic signed [C-1:0]               hi1, hi2;
    logic signed [C:0]                 lo1, lo2;
    // Stage D
    logic signed [lli_pkg::DET_W-1:0]  d_det_reg;
    logic signed [lli_pkg::NUM_W-1:0]  d_nx_reg, d_ny_reg;
    logic                              d_found_reg;
    // Stage E1
    logic signed [lli_pkg::NUMA_W-1:0] e1_nx_reg, e1_ny_reg;
    logic [lli_pkg::DET_W-1:0]         e1_deta_reg;
    logic                              e1_found_reg;
    // Stage E2
    logic signed [lli_pkg::N_W-1:0]    e2_nx_reg, e2_ny_reg;
    logic [lli_pkg::DEN_W-1:0]         e2_den_reg;
    logic                              e2_found_reg;
    // Stage E3
    logic [lli_pkg::M_W-1:0]           e3_mx_reg, e3_my_reg;
    logic [lli_pkg::DEN_W-1:0]         e3_den_reg;
    logic                              e3_found_reg, e3_negx_reg, e3_negy_reg;
    logic [lli_pkg::N_W-1:0]           magx, magy;
    // Stage E4
    lli_pkg::div_item_t                e4_item_reg;
    logic [lli_pkg::R0_W-1:0]          r0x, r0y;
    logic                              ovfx, ovfy;

    assign ax = s_line1_start_x[C-1:0];
    assign ay = s_line1_start_y[C-1:0];
    assign bx = s_line1_end_x[C-1:0];
    assign by = s_line1_end_y[C-1:0];
    assign cx = s_line2_start_x[C-1:0];
    assign cy = s_line2_start_y[C-1:0];
    assign ex = s_line2_end_x[C-1:0];
    assign ey = s_line2_end_y[C-1:0];

    // Each stage takes new data whenever it is empty or its successor moves on.
    always_comb begin
        rdy[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_in = {vld_reg[NS-2:0], s_valid};
    end

    assign s_ready   = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_item  = e4_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    always_comb begin
        hi1 = b_det1_reg[lli_pkg::DET1_W-1:C];
        hi2 = b_det2_reg[lli_pkg::DET1_W-1:C];
        lo1 = {1'b0, b_det1_reg[C-1:0]};
        lo2 = {1'b0, b_det2_reg[C-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_dx1_reg <= lli_pkg::DIFF_W'(bx) - lli_pkg::DIFF_W'(ax);
            a_dy1_reg <= lli_pkg::DIFF_W'(by) - lli_pkg::DIFF_W'(ay);
            a_dx2_reg <= lli_pkg::DIFF_W'(ex) - lli_pkg::DIFF_W'(cx);
            a_dy2_reg <= lli_pkg::DIFF_W'(ey) - lli_pkg::DIFF_W'(cy);
            a_p1_reg  <= lli_pkg::DET1_W'(ax) * lli_pkg::DET1_W'(by);
            a_p2_reg  <= lli_pkg::DET1_W'(ay) * lli_pkg::DET1_W'(bx);
            a_p3_reg  <= lli_pkg::DET1_W'(cx) * lli_pkg::DET1_W'(ey);
            a_p4_reg  <= lli_pkg::DET1_W'(cy) * lli_pkg::DET1_W'(ex);
        end
        if (rdy[1]) begin
            b_dx1_reg  <= a_dx1_reg;
            b_dy1_reg  <= a_dy1_reg;
            b_dx2_reg  <= a_dx2_reg;
            b_dy2_reg  <= a_dy2_reg;
            b_det1_reg <= a_p1_reg - a_p2_reg;
            b_det2_reg <= a_p3_reg - a_p4_reg;
            b_pd1_reg  <= lli_pkg::PP_W'(a_dx2_reg) * lli_pkg::PP_W'(a_dy1_reg);
            b_pd2_reg  <= lli_pkg::PP_W'(a_dy2_reg) * lli_pkg::PP_W'(a_dx1_reg);
        end
        // The wide determinants are split into a signed high half and an unsigned
        // low half so that every multiplier stays narrow.
        if (rdy[2]) begin
            c_det_reg <= lli_pkg::DET_W'(b_pd1_reg) - lli_pkg::DET_W'(b_pd2_reg);
            c_x1h_reg <= lli_pkg::PP_W'(b_dx2_reg) * lli_pkg::PP_W'(hi1);
            c_x1l_reg <= lli_pkg::PP_W'(b_dx2_reg) * lli_pkg::PP_W'(lo1);
            c_x2h_reg <= lli_pkg::PP_W'(b_dx1_reg) * lli_pkg::PP_W'(hi2);
            c_x2l_reg <= lli_pkg::PP_W'(b_dx1_reg) * lli_pkg::PP_W'(lo2);
            c_y1h_reg <= lli_pkg::PP_W'(b_dy2_reg) * lli_pkg::PP_W'(hi1);
            c_y1l_reg <= lli_pkg::PP_W'(b_dy2_reg) * lli_pkg::PP_W'(lo1);
            c_y2h_reg <= lli_pkg::PP_W'(b_dy1_reg) * lli_pkg::PP_W'(hi2);
            c_y2l_reg <= lli_pkg::PP_W'(b_dy1_reg) * lli_pkg::PP_W'(lo2);
        end
        if (rdy[3]) begin
            d_det_reg   <= c_det_reg;
            d_found_reg <= (c_det_reg != '0);
            d_nx_reg    <= ((lli_pkg::NUM_W'(c_x1h_reg) - lli_pkg::NUM_W'(c_x2h_reg)) <<< C)
                         + lli_pkg::NUM_W'(c_x1l_reg) - lli_pkg::NUM_W'(c_x2l_reg);
            d_ny_reg    <= ((lli_pkg::NUM_W'(c_y1h_reg) - lli_pkg::NUM_W'(c_y2h_reg)) <<< C)
                         + lli_pkg::NUM_W'(c_y1l_reg) - lli_pkg::NUM_W'(c_y2l_reg);
        end
        // A negative determinant flips the signs so that the divisor is positive.
        if (rdy[4]) begin
            e1_found_reg <= d_found_reg;
            if (d_det_reg[lli_pkg::DET_W-1]) begin
                e1_nx_reg   <= -lli_pkg::NUMA_W'(d_nx_reg);
                e1_ny_reg   <= -lli_pkg::NUMA_W'(d_ny_reg);
                e1_deta_reg <= -d_det_reg;
            end else begin
                e1_nx_reg   <= lli_pkg::NUMA_W'(d_nx_reg);
                e1_ny_reg   <= lli_pkg::NUMA_W'(d_ny_reg);
                e1_deta_reg <= d_det_reg;
            end
        end
        // Rounding half up: floor((2n * 2^F + d) / 2d).
        if (rdy[5]) begin
            e2_found_reg <= e1_found_reg;
            e2_den_reg   <= {e1_deta_reg, 1'b0};
            e2_nx_reg    <= (lli_pkg::N_W'(e1_nx_reg) <<< (lli_pkg::FRAC_BITS + 1))
                          + lli_pkg::N_W'($signed({1'b0, e1_deta_reg}));
            e2_ny_reg    <= (lli_pkg::N_W'(e1_ny_reg) <<< (lli_pkg::FRAC_BITS + 1))
                          + lli_pkg::N_W'($signed({1'b0, e1_deta_reg}));
        end
        if (rdy[6]) begin
            e3_found_reg <= e2_found_reg;
            e3_den_reg   <= e2_den_reg;
            e3_negx_reg  <= e2_nx_reg[lli_pkg::N_W-1];
            e3_negy_reg  <= e2_ny_reg[lli_pkg::N_W-1];
            e3_mx_reg    <= lli_pkg::M_W'(magx);
            e3_my_reg    <= lli_pkg::M_W'(magy);
        end
        if (rdy[7]) begin
            e4_item_reg.found <= e3_found_reg;
            e4_item_reg.neg_x <= e3_negx_reg;
            e4_item_reg.neg_y <= e3_negy_reg;
            e4_item_reg.ovf_x <= ovfx;
            e4_item_reg.ovf_y <= ovfy;
            e4_item_reg.den   <= e3_den_reg;
            e4_item_reg.x.rem <= ovfx ? '0 : lli_pkg::REM_W'(r0x);
            e4_item_reg.y.rem <= ovfy ? '0 : lli_pkg::REM_W'(r0y);
            e4_item_reg.x.quo <= e3_mx_reg[lli_pkg::OUT_W-1:0];
            e4_item_reg.y.quo <= e3_my_reg[lli_pkg::OUT_W-1:0];
        end
    end

    // For a negative dividend the floor quotient is minus the ceiling of the
    // magnitude, which equals (d - 1 - n) / d truncated.
    always_comb begin
        magx = e2_nx_reg[lli_pkg::N_W-1] ? (~e2_nx_reg + lli_pkg::N_W'(e2_den_reg))
                                         : e2_nx_reg;
        magy = e2_ny_reg[lli_pkg::N_W-1] ? (~e2_ny_reg + lli_pkg::N_W'(e2_den_reg))
                                         : e2_ny_reg;
    end

    // A quotient that needs more than the output width is flagged before the cells.
    always_comb begin
        r0x  = e3_mx_reg[lli_pkg::M_W-1:lli_pkg::OUT_W];
        r0y  = e3_my_reg[lli_pkg::M_W-1:lli_pkg::OUT_W];
        ovfx = lli_pkg::CMP_W'(r0x) >= lli_pkg::CMP_W'(e3_den_reg);
        ovfy = lli_pkg::CMP_W'(r0y) >= lli_pkg::CMP_W'(e3_den_reg);
    end

endmodule
`default_nettype wire

// File: rtl/core/lli_div_cell.sv
// One cell of the divider chain: one quotient bit for each coordinate.
`default_nettype none
module lli_div_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lli_pkg::div_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lli_pkg::div_item_t       out_item
);

    logic               vld_reg;
    lli_pkg::div_item_t item_reg;
    lli_pkg::div_item_t item_next;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next   = in_item;
        item_next.x = lli_pkg::div_step(in_item.x, in_item.den);
        item_next.y = lli_pkg::div_step(in_item.y, in_item.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/line_line_intersection_unit.sv
// Top level of the two-line intersection unit: front pipeline, divider chain, output register.
//
// Input channel s_*: one transaction carries two lines, each as two signed integer points.
// Output channel m_*: one transaction per input, in order, with the crossing point in
// signed fixed point (16 fraction bits, rounded half up), a found flag (zero when the
// lines are parallel, with zero coordinates) and a clipped flag when a coordinate
// saturated to the 48-bit range.
// Throughput is one transaction per cycle while m_ready stays high. The pipe has 8 stages
// for the determinants, the numerators and the rounding offset, one cell per quotient bit
// in a chain of 48 restoring-division cells, and the output register.
// Every stage and cell has its own valid bit and moves on whenever its successor is
// free, so a stalled receiver first fills the empty slots; s_ready falls only when the
// whole pipe is full. The m_* payload holds while m_valid waits for m_ready.
// Reset (aresetn low, synchronous) empties the pipe; no result is pending afterwards
// and the block accepts input in the next cycle.
`default_nettype none
module line_line_intersection_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_start_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_start_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_end_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line1_end_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_start_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_start_y,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_end_x,
    input  wire logic [lli_pkg::IN_W-1:0]   s_line2_end_y,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_crossing_found,
    output logic                            m_clipped,
    output logic signed [lli_pkg::OUT_W-1:0] m_cross_x,
    output logic signed [lli_pkg::OUT_W-1:0] m_cross_y
);

    localparam int NC = lli_pkg::OUT_W;

    lli_pkg::div_item_t chain_item [0:NC];
    logic               chain_vld  [0:NC];
    logic               chain_rdy  [0:NC];

    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic                       m_clipped_reg;
    logic [lli_pkg::OUT_W-1:0]  m_x_reg;
    logic [lli_pkg::OUT_W-1:0]  m_y_reg;
    lli_pkg::sat_t              sat_x, sat_y;

    lli_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line1_start_x (s_line1_start_x),
        .s_line1_start_y (s_line1_start_y),
        .s_line1_end_x   (s_line1_end_x),
        .s_line1_end_y   (s_line1_end_y),
        .s_line2_start_x (s_line2_start_x),
        .s_line2_start_y (s_line2_start_y),
        .s_line2_end_x   (s_line2_end_x),
        .s_line2_end_y   (s_line2_end_y),
        .out_valid       (chain_vld[0]),
        .out_ready       (chain_rdy[0]),
        .out_item        (chain_item[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        lli_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_vld[g]),
            .in_ready  (chain_rdy[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_vld[g+1]),
            .out_ready (chain_rdy[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    assign chain_rdy[NC] = !m_valid_reg || m_ready;

    always_comb begin
        sat_x = lli_pkg::saturate(chain_item[NC].x.quo, chain_item[NC].neg_x,
                                  chain_item[NC].ovf_x);
        sat_y = lli_pkg::saturate(chain_item[NC].y.quo, chain_item[NC].neg_y,
                                  chain_item[NC].ovf_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (chain_rdy[NC]) begin
            m_valid_reg <= chain_vld[NC];
        end
    end

    // Parallel lines report nothing but a cleared found flag.
    always_ff @(posedge aclk) begin
        if (chain_rdy[NC]) begin
            m_found_reg   <= chain_item[NC].found;
            m_clipped_reg <= chain_item[NC].found && (sat_x.clip || sat_y.clip);
            m_x_reg       <= chain_item[NC].found ? sat_x.val : '0;
            m_y_reg       <= chain_item[NC].found ? sat_y.val : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_crossing_found = m_found_reg;
    assign m_clipped        = m_clipped_reg;
    assign m_cross_x        = m_x_reg;
    assign m_cross_y        = m_y_reg;

    a_no_crossing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_crossing_found |-> !m_clipped && m_cross_x == '0 && m_cross_y == '0)
        else $error("parallel result carries nonzero fields");

    a_clip_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |->
            m_cross_x == lli_pkg::SAT_POS || m_cross_x == lli_pkg::SAT_NEG ||
            m_cross_y == lli_pkg::SAT_POS || m_cross_y == lli_pkg::SAT_NEG)
        else $error("clipped result has no saturated coordinate");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipe not empty after reset");

endmodule
`default_nettype wire

// File: sim/line_line_intersection_unit_test.sv
// Self-checking testbench for the two-line intersection unit with an in-order scoreboard.
module line_line_intersection_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [lli_pkg::IN_W-1:0] coord_t;
    typedef logic signed [127:0]             wide_t;

    typedef struct packed {
        coord_t ax, ay, bx, by, cx, cy, ex, ey;
    } line_pair_t;

    typedef struct packed {
        logic                             found;
        logic                             clip;
        logic signed [lli_pkg::OUT_W-1:0] x;
        logic signed [lli_pkg::OUT_W-1:0] y;
    } crossing_t;

    localparam coord_t CMAX = 25'sh0FFFFFF;
    localparam coord_t CMIN = 25'sh1000000;
    localparam int     LIMIT_CYCLES = 400000;
    localparam int     DRAIN_CYCLES = 80;

    class crossing_scoreboard;
        crossing_t pending_crossings[$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        // floor(num * 2^FRAC_BITS / den + 1/2) for den > 0, clamped to the output range.
        static function logic signed [lli_pkg::OUT_W-1:0] round_coord(wide_t num, wide_t den,
                                                                      inout logic clip);
            wide_t n, d, q;
            n = (num <<< (lli_pkg::FRAC_BITS + 1)) + den;
            d = den <<< 1;
            q = n / d;
            if (n < 0 && (n % d) != 0) q = q - 1;
            if (q > (wide_t'(1) <<< (lli_pkg::OUT_W - 1)) - 1) begin
                clip = 1'b1;
                return lli_pkg::SAT_POS;
            end
            if (q < -(wide_t'(1) <<< (lli_pkg::OUT_W - 1))) begin
                clip = 1'b1;
                return lli_pkg::SAT_NEG;
            end
            return q[lli_pkg::OUT_W-1:0];
        endfunction

        function void note(line_pair_t p);
            wide_t     ax, ay, bx, by, cx, cy, ex, ey;
            wide_t     dx1, dy1, dx2, dy2, det1, det2, det, nx, ny;
            crossing_t c;
            ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
            cx = p.cx; cy = p.cy; ex = p.ex; ey = p.ey;
            dx1 = bx - ax; dy1 = by - ay;
            dx2 = ex - cx; dy2 = ey - cy;
            det1 = ax * by - ay * bx;
            det2 = cx * ey - cy * ex;
            det  = dx2 * dy1 - dy2 * dx1;
            c = '0;
            if (det != 0) begin
                nx = dx2 * det1 - dx1 * det2;
                ny = dy2 * det1 - dy1 * det2;
                if (det < 0) begin
                    det = -det; nx = -nx; ny = -ny;
                end
                c.found = 1'b1;
                c.x = round_coord(nx, det, c.clip);
                c.y = round_coord(ny, det, c.clip);
            end
            pending_crossings.insert(pending_crossings.size(), c);
        endfunction

        function void check(crossing_t got);
            crossing_t want;
            if (pending_crossings.size() == 0) begin
                $display("%0t: unexpected result found=%0b clip=%0b x=%0d y=%0d", $time,
                         got.found, got.clip, got.x, got.y);
                failures++;
                return;
            end
            want = pending_crossings.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: crossing_found expected %0b actual %0b", $time,
                         want.found, got.found);
                failures++;
            end
            if (got.clip !== want.clip) begin
                $display("%0t: clipped expected %0b actual %0b", $time, want.clip, got.clip);
                failures++;
            end
            if (got.x !== want.x) begin
                $display("%0t: cross_x expected %0d actual %0d", $time, want.x, got.x);
                failures++;
            end
            if (got.y !== want.y) begin
                $display("%0t: cross_y expected %0d actual %0d", $time, want.y, got.y);
                failures++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_crossing_found, m_clipped;
    logic signed [lli_pkg::OUT_W-1:0] m_cross_x, m_cross_y;
    line_pair_t drive_pair = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;
    crossing_scoreboard sb = new();

    line_line_intersection_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_line1_start_x (drive_pair.ax),
        .s_line1_start_y (drive_pair.ay),
        .s_line1_end_x   (drive_pair.bx),
        .s_line1_end_y   (drive_pair.by),
        .s_line2_start_x (drive_pair.cx),
        .s_line2_start_y (drive_pair.cy),
        .s_line2_end_x   (drive_pair.ex),
        .s_line2_end_y   (drive_pair.ey),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_crossing_found(m_crossing_found),
        .m_clipped       (m_clipped),
        .m_cross_x       (m_cross_x),
        .m_cross_y       (m_cross_y)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL line_line_intersection_unit");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check(crossing_t'{m_crossing_found, m_clipped, m_cross_x, m_cross_y});
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pair(line_pair_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        drive_pair <= p;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note(p);
        @(negedge aclk);
    endtask

    function automatic coord_t rand_coord(int span);
        return coord_t'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic line_pair_t random_pair();
        line_pair_t   p;
        coord_t       ox, oy, a, c;
        int           mode;
        logic [223:0] raw;
        mode = $urandom_range(9);
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[199:0];
        case (mode)
            4, 5: begin
                p = '{rand_coord(1023), rand_coord(1023), rand_coord(1023), rand_coord(1023),
                      rand_coord(1023), rand_coord(1023), rand_coord(1023), rand_coord(1023)};
            end
            6: begin
                // Second line is the first one moved: parallel or coincident.
                p.ax = rand_coord(4194303); p.ay = rand_coord(4194303);
                p.bx = rand_coord(4194303); p.by = rand_coord(4194303);
                ox = ($urandom_range(3) == 0) ? coord_t'(0) : rand_coord(4194303);
                oy = ($urandom_range(3) == 0) ? coord_t'(0) : rand_coord(4194303);
                p.cx = p.ax + ox; p.cy = p.ay + oy;
                p.ex = p.bx + ox; p.ey = p.by + oy;
            end
            7: begin
                // Slopes differ by a hair, so for a nonzero c the crossing lands far out of range.
                a = coord_t'($urandom_range(24'hFFFFFE, 20'hFFFFF));
                c = rand_coord(7);
                p = '{0, 0, a, a - 1, 0, c, a - 1, a - 2 + c};
                if ($urandom_range(1)) p = '{0, 0, -a, a - 1, 0, c, 1 - a, a - 2 + c};
            end
            8: begin
                p.bx = p.ax; p.by = p.ay;
                if ($urandom_range(1)) begin
                    p.ex = p.cx; p.ey = p.cy;
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_pair(random_pair());
    endtask

    initial begin
        line_pair_t directed[$];
        directed = '{
            '{0, 0, 2, 2, 0, 2, 2, 0},
            '{0, 0, 3, 1, 0, 5, 3, 6},
            '{7, 7, 7, 7, 0, 0, 5, 9},
            '{7, 7, 7, 7, 3, 3, 3, 3},
            '{0, 0, 4, 4, 8, 8, -4, -4},
            '{0, 0, 1, 131072, 0, 1, 5, 1},
            '{0, 0, -1, 131072, 0, 1, 5, 1},
            '{0, 0, 1, 3, 0, 1, 5, 1},
            '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX},
            '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN},
            '{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN},
            '{CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN},
            '{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX},
            '{0, 0, CMAX, CMAX - 1, 0, 1, CMAX - 1, CMAX - 1},
            '{0, 0, -CMAX, CMAX - 1, 0, 1, 1 - CMAX, CMAX - 1},
            '{0, 0, CMAX, CMAX - 1, 0, -1, CMAX - 1, CMAX - 3},
            '{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX - 1},
            '{-3, -5, 11, 2, 4, -9, -6, 13}
        };
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 26;
        recv_idle_pct = 51;
        foreach (directed[i]) send_pair(directed[i]);
        run_random(320);

        // Hold off until the pipe has fully drained.
        s_valid <= 1'b0;
        while (sb.pending_crossings.size() != 0) @(negedge aclk);

        send_idle_pct = 51;
        recv_idle_pct = 26;
        run_random(340);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(340);
        s_valid <= 1'b0;

        while (sb.pending_crossings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("PASS line_line_intersection_unit");
        end else begin
            $display("FAIL line_line_intersection_unit");
        end
        $finish;
    end
endmodule
